### src/mono_lcd_framebuffer_line_sender_top_assert.svh
// Assertion macros used by the line sender controller.
`ifndef MONO_LCD_FRAMEBUFFER_LINE_SENDER_TOP_ASSERT_SVH
`define MONO_LCD_FRAMEBUFFER_LINE_SENDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside of reset.
`define MLFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define MLFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MLFB_ASSERT(lbl, prop, msg)
`define MLFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/mlfb_pkg.sv
// Package with the constants, codes and control types of the line sender.
package mlfb_pkg;

  localparam int DISPLAY_WIDTH  = 400;
  localparam int DISPLAY_HEIGHT = 240;
  localparam int ROW_BYTES      = (DISPLAY_WIDTH + 7) / 8;
  localparam int MEM_DEPTH      = DISPLAY_HEIGHT * ROW_BYTES;
  localparam int ADDR_W         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W          = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_IDX_W      = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;

  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] LINE_CMD_BYTE   = 8'h01;
  localparam logic [7:0] CLEAR_CMD_BYTE  = 8'h04;
  localparam logic [7:0] THRESHOLD_RESET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ROWS = 2'd2;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_LINE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SRC_WRITE_LINE,
    SRC_ADDR,
    SRC_DATA,
    SRC_ZERO,
    SRC_ALL_CLEAR
  } src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_PIX_FILL,
    ST_LN_CMD,
    ST_LN_ADDR,
    ST_LN_RD,
    ST_LN_DAT,
    ST_LN_DUMMY,
    ST_LN_TRL0,
    ST_LN_TRL1,
    ST_CLR_CMD,
    ST_CLR_END
  } state_e;

  typedef struct packed {
    logic capture;
    logic calc;
    logic cnt_clr;
    logic cnt_inc;
    logic mem_rd;
    logic addr_cnt;
    logic pix_write;
    logic fill_write;
    logic set_valid;
    logic clear_all;
    logic emit;
    src_e emit_src;
    logic emit_rel;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pix_in_range;
    logic       line_in_range;
    logic       first;
    logic       final_ln;
    logic       row_valid;
    logic       cnt_last;
    logic       slot_free;
  } status_t;

endpackage

### src/mlfb_datapath.sv
// Datapath: input capture, settings, pixel store, row valid bits and output register.
module mlfb_datapath import mlfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            operation_i,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [COLOR_W-1:0]    pixel_color_i,
  input  logic                  first_line_i,
  input  logic                  final_line_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            spi_byte_o,
  output logic                  release_select_o,
  output logic                  last_o,
  input  cmd_t                  cmd_i,
  output status_t               status_o
);

  function automatic logic [7:0] luma(input logic [COLOR_W-1:0] c);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] sum;
    r8  = {c[15:11], c[15:13]};
    g8  = {c[10:5], c[10:9]};
    b8  = {c[4:0], c[4:2]};
    sum = 16'(16'd77 * 16'(r8)) + 16'(16'd150 * 16'(g8)) + 16'(16'd29 * 16'(b8));
    return sum[15:8];
  endfunction

  // Captured item.
  logic [1:0]         op_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [COLOR_W-1:0] color_q;
  logic               first_q;
  logic               final_q;

  // Settings.
  logic [7:0] thr_q;
  logic       mir_c_q;
  logic       mir_r_q;

  // Values worked out in the decode cycle.
  logic [ADDR_W-1:0] row_base_q;
  logic [CNT_W-1:0]  byte_q;
  logic [2:0]        bit_q;
  logic              white_q;

  logic [CNT_W-1:0]          cnt_q;
  logic [DISPLAY_HEIGHT-1:0] row_valid_q;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_rel_q;
  logic       out_last_q;

  logic [COL_W-1:0]  px;
  logic [ROW_W-1:0]  py;
  logic [ROW_W-1:0]  tgt_row;
  logic              pix_in_range;
  logic              line_in_range;
  logic              tgt_in_range;
  logic              row_valid;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mask;
  logic [7:0]        mod_rd;
  logic [7:0]        mod_ff;
  logic [7:0]        wdata;
  logic [7:0]        emit_byte;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      col_q   <= column_i;
      row_q   <= row_i;
      color_q <= pixel_color_i;
      first_q <= first_line_i;
      final_q <= final_line_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RESET;
      mir_c_q <= 1'b1;
      mir_r_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:   thr_q   <= cfg_data_i;
        CFG_MIRROR_COLS: mir_c_q <= cfg_data_i[0];
        CFG_MIRROR_ROWS: mir_r_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign pix_in_range  = (32'(col_q) < DISPLAY_WIDTH) && (32'(row_q) < DISPLAY_HEIGHT);
  assign line_in_range = 32'(row_q) < DISPLAY_HEIGHT;
  assign px = mir_c_q ? COL_W'(DISPLAY_WIDTH - 1) - col_q : col_q;
  assign py = mir_r_q ? ROW_W'(DISPLAY_HEIGHT - 1) - row_q : row_q;
  assign tgt_row      = (op_q == OP_PIXEL) ? py : row_q;
  assign tgt_in_range = (op_q == OP_PIXEL) ? pix_in_range : line_in_range;
  assign row_valid    = tgt_in_range && row_valid_q[tgt_row[ROW_IDX_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      row_base_q <= ADDR_W'(32'(tgt_row) * ROW_BYTES);
      byte_q     <= CNT_W'(px >> 3);
      bit_q      <= px[2:0];
      white_q    <= luma(color_q) >= thr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // A row whose bit is clear reads as all white; the first pixel write to it fills it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      row_valid_q <= '0;
    end else if (cmd_i.set_valid) begin
      row_valid_q[tgt_row[ROW_IDX_W-1:0]] <= 1'b1;
    end
  end

  assign mem_addr = row_base_q + ADDR_W'(cmd_i.addr_cnt ? cnt_q : byte_q);
  assign mask     = 8'(1) << bit_q;
  assign mod_rd   = white_q ? (rdata_q | mask) : (rdata_q & ~mask);
  assign mod_ff   = white_q ? 8'hFF : ~mask;
  assign wdata    = cmd_i.fill_write ? ((cnt_q == byte_q) ? mod_ff : 8'hFF) : mod_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_write || cmd_i.fill_write) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    unique case (cmd_i.emit_src)
      SRC_WRITE_LINE: emit_byte = LINE_CMD_BYTE;
      SRC_ADDR:       emit_byte = row_q + 8'd1;
      SRC_DATA:       emit_byte = row_valid ? rdata_q : 8'hFF;
      SRC_ALL_CLEAR:  emit_byte = CLEAR_CMD_BYTE;
      default:        emit_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_rel_q  <= cmd_i.emit_rel;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign spi_byte_o       = out_byte_q;
  assign release_select_o = out_rel_q;
  assign last_o           = out_last_q;

  assign status_o.op            = op_q;
  assign status_o.pix_in_range  = pix_in_range;
  assign status_o.line_in_range = line_in_range;
  assign status_o.first         = first_q;
  assign status_o.final_ln      = final_q;
  assign status_o.row_valid     = row_valid;
  assign status_o.cnt_last      = cnt_q == CNT_W'(ROW_BYTES - 1);
  assign status_o.slot_free     = !out_valid_q || out_ready_i;

endmodule

### src/mlfb_ctrl.sv
// Controller state machine that sequences pixel writes, line sends and clears.
`include "mono_lcd_framebuffer_line_sender_top_assert.svh"
module mlfb_ctrl import mlfb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q;
  state_e state_d;
  state_e after_cmd;
  state_e after_dummy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign after_cmd   = status_i.line_in_range ? ST_LN_ADDR :
                       (status_i.final_ln ? ST_LN_TRL0 : ST_IDLE);
  assign after_dummy = status_i.final_ln ? ST_LN_TRL0 : ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (status_i.op)
          OP_PIXEL: begin
            if (!status_i.pix_in_range) state_d = ST_IDLE;
            else if (status_i.row_valid) state_d = ST_PIX_RD;
            else state_d = ST_PIX_FILL;
          end
          OP_LINE:  state_d = status_i.first ? ST_LN_CMD : after_cmd;
          OP_CLEAR: state_d = ST_CLR_CMD;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_PIX_RD:   state_d = ST_PIX_WR;
      ST_PIX_WR:   state_d = ST_IDLE;
      ST_PIX_FILL: begin
        if (status_i.cnt_last) state_d = ST_IDLE;
      end
      ST_LN_CMD: begin
        if (status_i.slot_free) state_d = after_cmd;
      end
      ST_LN_ADDR: begin
        if (status_i.slot_free) state_d = ST_LN_RD;
      end
      ST_LN_RD: state_d = ST_LN_DAT;
      ST_LN_DAT: begin
        if (status_i.slot_free) state_d = status_i.cnt_last ? ST_LN_DUMMY : ST_LN_RD;
      end
      ST_LN_DUMMY: begin
        if (status_i.slot_free) state_d = after_dummy;
      end
      ST_LN_TRL0: begin
        if (status_i.slot_free) state_d = ST_LN_TRL1;
      end
      ST_LN_TRL1: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      ST_CLR_CMD: begin
        if (status_i.slot_free) state_d = ST_CLR_END;
      end
      ST_CLR_END: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.calc    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      ST_PIX_RD: cmd_o.mem_rd = 1'b1;
      ST_PIX_WR: cmd_o.pix_write = 1'b1;
      ST_PIX_FILL: begin
        cmd_o.addr_cnt   = 1'b1;
        cmd_o.fill_write = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.set_valid  = status_i.cnt_last;
      end
      ST_LN_CMD: begin
        cmd_o.emit      = status_i.slot_free;
        cmd_o.emit_src  = SRC_WRITE_LINE;
        cmd_o.emit_last = !status_i.line_in_range && !status_i.final_ln;
      end
      ST_LN_ADDR: begin
        cmd_o.emit     = status_i.slot_free;
        cmd_o.emit_src = SRC_ADDR;
      end
      ST_LN_RD: begin
        cmd_o.addr_cnt = 1'b1;
        cmd_o.mem_rd   = 1'b1;
      end
      ST_LN_DAT: begin
        cmd_o.emit     = status_i.slot_free;
        cmd_o.emit_src = SRC_DATA;
        cmd_o.cnt_inc  = status_i.slot_free;
      end
      ST_LN_DUMMY: begin
        cmd_o.emit      = status_i.slot_free;
        cmd_o.emit_src  = SRC_ZERO;
        cmd_o.emit_last = !status_i.final_ln;
      end
      ST_LN_TRL0: begin
        cmd_o.emit     = status_i.slot_free;
        cmd_o.emit_src = SRC_ZERO;
      end
      ST_LN_TRL1: begin
        cmd_o.emit      = status_i.slot_free;
        cmd_o.emit_src  = SRC_ZERO;
        cmd_o.emit_rel  = 1'b1;
        cmd_o.emit_last = 1'b1;
      end
      ST_CLR_CMD: begin
        cmd_o.emit     = status_i.slot_free;
        cmd_o.emit_src = SRC_ALL_CLEAR;
      end
      ST_CLR_END: begin
        cmd_o.emit      = status_i.slot_free;
        cmd_o.emit_src  = SRC_ZERO;
        cmd_o.emit_rel  = 1'b1;
        cmd_o.emit_last = 1'b1;
        cmd_o.clear_all = status_i.slot_free;
      end
      default: ;
    endcase
  end

  `MLFB_ASSERT(a_emit_into_free_slot, cmd_o.emit |-> status_i.slot_free, "beat loaded over a waiting beat")
  `MLFB_ASSERT(a_release_is_last, (cmd_o.emit && cmd_o.emit_rel) |-> cmd_o.emit_last, "release on a beat that is not last")
  `MLFB_ASSERT(a_accept_goes_decode, (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE), "accepted item skipped decode")
  `MLFB_ASSERT_ALWAYS(a_idle_is_quiet, (state_q == ST_IDLE) |-> !(cmd_o.emit || cmd_o.pix_write || cmd_o.fill_write), "store or output touched while idle")

endmodule

### src/mono_lcd_framebuffer_line_sender_top.sv
// Top level of the one-bit framebuffer and line sender for a memory display.
// Pixel write: decode, store read, then store write, and back to idle for the next item;
//   the first write to a row after reset or clear sweeps the whole row instead.
// Line send: each pixel byte is set by one store read and one output load; all-clear
//   sends a command beat and an end beat.
// Reset is asynchronous and active low; it drops every row valid bit and restores settings.
module mono_lcd_framebuffer_line_sender_top import mlfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [COLOR_W-1:0]    pixel_color_i,
  input  logic                  first_line_i,
  input  logic                  final_line_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            spi_byte_o,
  output logic                  release_select_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // The controller works on one item at a time. It takes a new item only in its idle
  // state, and a beat left in the output register may still wait there while the next
  // item is accepted, so the two sides of the block stay decoupled.
  //
  // The store is a single-port byte memory of DISPLAY_HEIGHT rows of ROW_BYTES bytes.
  // Each row has a valid bit; a row whose bit is clear reads as all white. The first
  // pixel write to such a row sweeps the whole row, writing white everywhere and the new
  // pixel in its byte, and then sets the bit. All-clear just drops every valid bit, and
  // reset does the same, so no clearing pass is needed. The settings come back as
  // threshold 128 with both mirrors on.
  //
  // A pixel write computes the luminance and the store address in the decode cycle,
  // then, in a valid row, reads the byte and writes it back with the one bit changed.
  //
  // A line send streams its bytes through the output register: an optional command
  // beat, the 1-based row address, the row's pixel bytes, a dummy beat, and two trailer
  // beats when the line ends the frame. Each pixel byte is read from the store into the
  // read register, then loaded into the output register once that register is free.

  cmd_t    cmd;
  status_t status;

  mlfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mlfb_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .pixel_color_i    (pixel_color_i),
    .first_line_i     (first_line_i),
    .final_line_i     (final_line_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .spi_byte_o       (spi_byte_o),
    .release_select_o (release_select_o),
    .last_o           (last_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule
